@@ design/qvr_pkg.sv @@
// Shared types for the quaternion vector rotator: port words and the
// per-stage word of the restoring divider. No dependencies.
package qvr_pkg;

    localparam int DivSteps = 32;

    typedef struct packed {
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [31:0] vec_x;
        logic signed [31:0] vec_y;
        logic signed [31:0] vec_z;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] rot_x;
        logic signed [31:0] rot_y;
        logic signed [31:0] rot_z;
        logic               zero_norm;
        logic               saturated;
    } out_word_t;

    // One output row inside the divider: sign of the dot product, quotient
    // overflow, partial remainder, dividend bits not yet shifted in, quotient.
    typedef struct packed {
        logic        neg;
        logic        big;
        logic [32:0] rem;
        logic [31:0] low;
        logic [31:0] quo;
    } div_row_t;

    typedef struct packed {
        div_row_t [2:0] row;
        logic [32:0]    n;
        logic           zero;
    } div_word_t;

endpackage

@@ design/qvr_front.sv @@
// Front end of the rotator: quaternion products, scaled rotation matrix,
// matrix-vector products and divider setup, four register stages.
// Depends on qvr_pkg.
module qvr_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    input  qvr_pkg::in_word_t    in_data,
    output logic                 in_ready,
    output logic                 out_valid,
    output qvr_pkg::div_word_t   out_data,
    input  logic                 out_ready
);

    typedef struct packed {
        logic signed [31:0] ww;
        logic signed [31:0] xx;
        logic signed [31:0] yy;
        logic signed [31:0] zz;
        logic signed [31:0] xy;
        logic signed [31:0] xz;
        logic signed [31:0] yz;
        logic signed [31:0] wx;
        logic signed [31:0] wy;
        logic signed [31:0] wz;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
    } prod_t;

    typedef struct packed {
        logic signed [2:0][2:0][34:0] m;
        logic signed [32:0]           n;
        logic signed [2:0][31:0]      p;
    } mat_t;

    typedef struct packed {
        logic signed [2:0][2:0][66:0] t;
        logic [32:0]                  n;
    } term_t;

    logic       v1_reg, v2_reg, v3_reg, v4_reg;
    logic       rdy1, rdy2, rdy3, rdy4;
    prod_t      s1_reg, s1_next;
    mat_t       s2_reg, s2_next;
    term_t      s3_reg, s3_next;
    qvr_pkg::div_word_t s4_reg, s4_next;

    assign rdy4     = !v4_reg || out_ready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_comb begin
        s1_next.ww = 32'(in_data.quat_w) * 32'(in_data.quat_w);
        s1_next.xx = 32'(in_data.quat_x) * 32'(in_data.quat_x);
        s1_next.yy = 32'(in_data.quat_y) * 32'(in_data.quat_y);
        s1_next.zz = 32'(in_data.quat_z) * 32'(in_data.quat_z);
        s1_next.xy = 32'(in_data.quat_x) * 32'(in_data.quat_y);
        s1_next.xz = 32'(in_data.quat_x) * 32'(in_data.quat_z);
        s1_next.yz = 32'(in_data.quat_y) * 32'(in_data.quat_z);
        s1_next.wx = 32'(in_data.quat_w) * 32'(in_data.quat_x);
        s1_next.wy = 32'(in_data.quat_w) * 32'(in_data.quat_y);
        s1_next.wz = 32'(in_data.quat_w) * 32'(in_data.quat_z);
        s1_next.px = in_data.vec_x;
        s1_next.py = in_data.vec_y;
        s1_next.pz = in_data.vec_z;
    end

    always_comb begin
        logic signed [34:0] ww, xx, yy, zz, xy, xz, yz, wx, wy, wz;
        ww = 35'(s1_reg.ww);
        xx = 35'(s1_reg.xx);
        yy = 35'(s1_reg.yy);
        zz = 35'(s1_reg.zz);
        xy = 35'(s1_reg.xy);
        xz = 35'(s1_reg.xz);
        yz = 35'(s1_reg.yz);
        wx = 35'(s1_reg.wx);
        wy = 35'(s1_reg.wy);
        wz = 35'(s1_reg.wz);
        s2_next.m[0][0] = ww + xx - yy - zz;
        s2_next.m[0][1] = (xy - wz) <<< 1;
        s2_next.m[0][2] = (xz + wy) <<< 1;
        s2_next.m[1][0] = (xy + wz) <<< 1;
        s2_next.m[1][1] = ww - xx + yy - zz;
        s2_next.m[1][2] = (yz - wx) <<< 1;
        s2_next.m[2][0] = (xz - wy) <<< 1;
        s2_next.m[2][1] = (yz + wx) <<< 1;
        s2_next.m[2][2] = ww - xx - yy + zz;
        s2_next.n       = 33'(ww + xx + yy + zz);
        s2_next.p[0]    = s1_reg.px;
        s2_next.p[1]    = s1_reg.py;
        s2_next.p[2]    = s1_reg.pz;
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                s3_next.t[r][c] = 67'($signed(s2_reg.m[r][c])) * 67'($signed(s2_reg.p[c]));
            end
        end
        s3_next.n = s2_reg.n;
    end

    // Split |acc| into the top 36 bits, which seed the remainder, and the
    // low 32 bits that the divider shifts in one per stage.
    always_comb begin
        logic signed [68:0] acc;
        logic [68:0]        mag;
        logic [35:0]        hi;
        for (int r = 0; r < 3; r++) begin
            acc = 69'($signed(s3_reg.t[r][0])) + 69'($signed(s3_reg.t[r][1]))
                + 69'($signed(s3_reg.t[r][2]));
            mag = acc[68] ? 69'(-acc) : 69'(acc);
            hi  = mag[67:32];
            s4_next.row[r].neg = acc[68];
            s4_next.row[r].big = hi >= {3'b000, s3_reg.n};
            s4_next.row[r].rem = (hi >= {3'b000, s3_reg.n}) ? '0 : hi[32:0];
            s4_next.row[r].low = mag[31:0];
            s4_next.row[r].quo = '0;
        end
        s4_next.n    = s3_reg.n;
        s4_next.zero = (s3_reg.n == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && in_valid) s1_reg <= s1_next;
        if (rdy2 && v1_reg)   s2_reg <= s2_next;
        if (rdy3 && v2_reg)   s3_reg <= s3_next;
        if (rdy4 && v3_reg)   s4_reg <= s4_next;
    end

    assign out_valid = v4_reg;
    assign out_data  = s4_reg;

endmodule

@@ design/qvr_div_step.sv @@
// One restoring-division stage: one quotient bit for each of the three rows.
// Depends on qvr_pkg.
module qvr_div_step (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    input  qvr_pkg::div_word_t   in_data,
    output logic                 in_ready,
    output logic                 out_valid,
    output qvr_pkg::div_word_t   out_data,
    input  logic                 out_ready
);

    logic               valid_reg;
    qvr_pkg::div_word_t data_reg, data_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        logic [33:0] trial;
        logic        ge;
        data_next = in_data;
        for (int r = 0; r < 3; r++) begin
            trial = {in_data.row[r].rem, in_data.row[r].low[31]};
            ge    = trial >= {1'b0, in_data.n};
            data_next.row[r].rem = ge ? 33'(trial - {1'b0, in_data.n}) : trial[32:0];
            data_next.row[r].low = {in_data.row[r].low[30:0], 1'b0};
            data_next.row[r].quo = {in_data.row[r].quo[30:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

@@ design/qvr_round.sv @@
// Output stage: round half away from zero, apply sign, saturate, and hold
// the result word. Depends on qvr_pkg.
module qvr_round (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    input  qvr_pkg::div_word_t   in_data,
    output logic                 in_ready,
    output logic                 out_valid,
    output qvr_pkg::out_word_t   out_data,
    input  logic                 out_ready
);

    logic               valid_reg;
    qvr_pkg::out_word_t data_reg, data_next;
    logic [2:0][31:0]   val;
    logic [2:0]         clip;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        logic [32:0] q;
        logic        up;
        for (int r = 0; r < 3; r++) begin
            up = {in_data.row[r].rem, 1'b0} >= {1'b0, in_data.n};
            q  = {1'b0, in_data.row[r].quo} + {32'd0, up};
            if (in_data.row[r].neg) begin
                clip[r] = in_data.row[r].big || (q > 33'h0_8000_0000);
                val[r]  = clip[r] ? 32'h8000_0000 : 32'(~q + 33'd1);
            end else begin
                clip[r] = in_data.row[r].big || (q > 33'h0_7fff_ffff);
                val[r]  = clip[r] ? 32'h7fff_ffff : q[31:0];
            end
        end
        if (in_data.zero) begin
            data_next.rot_x     = '0;
            data_next.rot_y     = '0;
            data_next.rot_z     = '0;
            data_next.zero_norm = 1'b1;
            data_next.saturated = 1'b0;
        end else begin
            data_next.rot_x     = val[0];
            data_next.rot_y     = val[1];
            data_next.rot_z     = val[2];
            data_next.zero_norm = 1'b0;
            data_next.saturated = |clip;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

@@ design/quaternion_vector_rotate.sv @@
// Top level of the quaternion vector rotator: front end, divider chain and
// output stage. Depends on qvr_pkg, qvr_front, qvr_div_step, qvr_round.
//
//   channel   ports                      word
//   input     s_valid s_ready s_data     qvr_pkg::in_word_t
//   result    m_valid m_ready m_data     qvr_pkg::out_word_t
//
// The pipeline has four front-end stages, 32 divider stages (one
// quotient bit each) and one output stage. One word enters per cycle unless a full pipeline is held.
// Reset clears only the stage valid bits.
// Each stage stalls on its own, so bubbles close up while the output is held.
module quaternion_vector_rotate (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  qvr_pkg::in_word_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output qvr_pkg::out_word_t  m_data
);

    logic               dv    [0:qvr_pkg::DivSteps];
    logic               drdy  [0:qvr_pkg::DivSteps];
    qvr_pkg::div_word_t dword [0:qvr_pkg::DivSteps];

    qvr_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_data   (s_data),
        .in_ready  (s_ready),
        .out_valid (dv[0]),
        .out_data  (dword[0]),
        .out_ready (drdy[0])
    );

    for (genvar i = 0; i < qvr_pkg::DivSteps; i++) begin : g_div
        qvr_div_step u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (dv[i]),
            .in_data   (dword[i]),
            .in_ready  (drdy[i]),
            .out_valid (dv[i+1]),
            .out_data  (dword[i+1]),
            .out_ready (drdy[i+1])
        );
    end

    qvr_round u_round (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (dv[qvr_pkg::DivSteps]),
        .in_data   (dword[qvr_pkg::DivSteps]),
        .in_ready  (drdy[qvr_pkg::DivSteps]),
        .out_valid (m_valid),
        .out_data  (m_data),
        .out_ready (m_ready)
    );

`ifndef SYNTH
    a_zero_norm_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.zero_norm |->
            m_data.rot_x == '0 && m_data.rot_y == '0 && m_data.rot_z == '0
            && !m_data.saturated)
        else $error("zero-norm word carries nonzero payload");

    a_sat_at_rail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.saturated |->
            m_data.rot_x == 32'h7fff_ffff || m_data.rot_x == 32'h8000_0000
            || m_data.rot_y == 32'h7fff_ffff || m_data.rot_y == 32'h8000_0000
            || m_data.rot_z == 32'h7fff_ffff || m_data.rot_z == 32'h8000_0000)
        else $error("saturated flag without a clipped component");

    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled while output stage is empty");
`endif

endmodule

@@ sim/quaternion_vector_rotate_test.sv @@
`timescale 1ns / 1ps
// Self-checking bench for quaternion_vector_rotate: random and corner-case words
// are checked against an exact wide-integer rotation predictor. Depends on qvr_pkg.
module quaternion_vector_rotate_test;

    localparam int NumRandom = 1850;
    localparam int CycleLimit = 400000;
    localparam int Latency = 37;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    qvr_pkg::in_word_t  s_data = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    qvr_pkg::out_word_t m_data;

    qvr_pkg::in_word_t  word_queue[$];
    qvr_pkg::out_word_t rotation_queue[$];
    int        mismatches = 0;
    int        words_sent = 0;
    int        words_seen = 0;
    int        cycles = 0;
    int        send_idle = 0;
    int        recv_idle = 0;
    int        holdoff = 0;
    bit        holdoff_done = 1'b0;
    bit        calm_phase = 1'b0;
    int        total_words = 0;

    quaternion_vector_rotate dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // One row of (M * p) / n, rounded half away from zero, clipped to 32 bits.
    function automatic logic signed [31:0] rotate_row(
        input logic signed [127:0] m0, m1, m2, p0, p1, p2,
        input logic [127:0] n, inout logic sat);
        logic signed [127:0] acc;
        logic [127:0] mag, quo, rem;
        logic neg;
        acc = m0 * p0 + m1 * p1 + m2 * p2;
        neg = acc[127];
        mag = neg ? -acc : acc;
        quo = mag / n;
        rem = mag % n;
        if (2 * rem >= n) quo = quo + 1;
        if (neg) begin
            if (quo > 128'h8000_0000) begin
                sat = 1'b1;
                return 32'sh8000_0000;
            end
            return -quo[31:0];
        end
        if (quo > 128'h7fff_ffff) begin
            sat = 1'b1;
            return 32'sh7fff_ffff;
        end
        return quo[31:0];
    endfunction

    function automatic qvr_pkg::out_word_t predict_rotation(input qvr_pkg::in_word_t q);
        logic signed [127:0] w, x, y, z, px, py, pz, ww, xx, yy, zz;
        logic signed [127:0] xy, xz, yz, wx, wy, wz;
        logic [127:0] n;
        logic sat;
        qvr_pkg::out_word_t r;
        w = q.quat_w; x = q.quat_x; y = q.quat_y; z = q.quat_z;
        px = q.vec_x; py = q.vec_y; pz = q.vec_z;
        ww = w * w; xx = x * x; yy = y * y; zz = z * z;
        xy = x * y; xz = x * z; yz = y * z;
        wx = w * x; wy = w * y; wz = w * z;
        n = ww + xx + yy + zz;
        sat = 1'b0;
        r = '0;
        if (n == 0) begin
            r.zero_norm = 1'b1;
            return r;
        end
        r.rot_x = rotate_row(ww + xx - yy - zz, 2 * (xy - wz), 2 * (xz + wy),
                             px, py, pz, n, sat);
        r.rot_y = rotate_row(2 * (xy + wz), ww - xx + yy - zz, 2 * (yz - wx),
                             px, py, pz, n, sat);
        r.rot_z = rotate_row(2 * (xz - wy), 2 * (yz + wx), ww - xx - yy + zz,
                             px, py, pz, n, sat);
        r.saturated = sat;
        return r;
    endfunction

    function automatic logic [15:0] rand_quat_part();
        case ($urandom_range(0, 5))
            0: return 16'($urandom_range(0, 4)) - 16'd2;
            1: return 16'h8000;
            2: return 16'h7fff;
            3: return 16'($signed($urandom_range(0, 32768)) - 16384);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] rand_vec_part();
        case ($urandom_range(0, 4))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
            default: return 32'($urandom);
        endcase
    endfunction

    task automatic add_word(input logic [15:0] qw, qx, qy, qz,
                            input logic [31:0] vx, vy, vz);
        qvr_pkg::in_word_t t;
        t.quat_w = qw; t.quat_x = qx; t.quat_y = qy; t.quat_z = qz;
        t.vec_x = vx; t.vec_y = vy; t.vec_z = vz;
        word_queue.push_back(t);
    endtask

    initial begin
        // zero quaternion, with and without a vector
        add_word(0, 0, 0, 0, 0, 0, 0);
        add_word(0, 0, 0, 0, 32'h7fff_ffff, 32'h8000_0000, 32'h1234_5678);
        // identity and its negative
        add_word(16'h4000, 0, 0, 0, 32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000);
        add_word(16'hc000, 0, 0, 0, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
        // 90 and 180 degree turns about each axis
        add_word(16'h2d41, 16'h2d41, 0, 0, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
        add_word(16'h2d41, 0, 16'h2d41, 0, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
        add_word(16'h2d41, 0, 0, 16'h2d41, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
        add_word(0, 16'h4000, 0, 0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
        add_word(0, 0, 16'h4000, 0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
        add_word(0, 0, 0, 16'h4000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
        // extreme components
        add_word(16'h8000, 16'h8000, 16'h8000, 16'h8000,
                 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        add_word(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        add_word(16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
                 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
        // tiny norms: exact, rounding ties and clipping past the range
        add_word(1, 0, 0, 0, 32'h0000_0003, 32'hffff_fffd, 0);
        add_word(1, 1, 0, 0, 32'h0000_0001, 32'hffff_ffff, 32'h0000_0003);
        add_word(1, 1, 1, 0, 32'h0000_0001, 32'h0000_0002, 32'hffff_ffff);
        add_word(0, 1, 1, 1, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0005);
        add_word(1, 1, 1, 1, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
        add_word(16'hffff, 16'h0001, 0, 16'hffff, 32'h7fff_ffff, 32'h7fff_fffe, 0);
        add_word(0, 16'h8000, 16'h8000, 0, 32'h8000_0000, 0, 32'h7fff_ffff);
        add_word(16'h0003, 16'hfffd, 16'h0001, 16'h0002, 32'h0000_0007,
                 32'hffff_fff9, 32'h0000_000b);
        for (int i = 0; i < NumRandom; i++) begin
            if ($urandom_range(0, 39) == 0)
                add_word(0, 0, 0, 0, rand_vec_part(), rand_vec_part(), rand_vec_part());
            else
                add_word(rand_quat_part(), rand_quat_part(), rand_quat_part(),
                         rand_quat_part(), rand_vec_part(), rand_vec_part(),
                         rand_vec_part());
        end
        total_words = word_queue.size();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        wait (words_sent == total_words);
        while (rotation_queue.size() != 0) @(posedge aclk);
        repeat (Latency + 20) @(posedge aclk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Input driver: take a word from the pending queue, idling in bursts.
    always @(posedge aclk) begin
        if (s_valid && s_ready) begin
            rotation_queue.push_back(predict_rotation(s_data));
            words_sent <= words_sent + 1;
        end
        if (aresetn && (!s_valid || s_ready)) begin
            calm_phase <= (word_queue.size() < 150) || ((words_sent / 200) % 3 == 2);
            if (send_idle > 0) begin
                send_idle <= send_idle - 1;
                s_valid <= 1'b0;
            end else if (!calm_phase && $urandom_range(0, 9) == 0) begin
                send_idle <= $urandom_range(0, 11);
                s_valid <= 1'b0;
            end else if (word_queue.size() > 0) begin
                s_data <= word_queue.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result side: check each word against the oldest prediction.
    always @(posedge aclk) begin
        if (m_valid && m_ready) begin
            words_seen <= words_seen + 1;
            if (rotation_queue.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("unexpected result word %p", m_data);
            end else begin
                qvr_pkg::out_word_t want;
                want = rotation_queue.pop_front();
                if (want.rot_x !== m_data.rot_x || want.rot_y !== m_data.rot_y ||
                    want.rot_z !== m_data.rot_z || want.zero_norm !== m_data.zero_norm ||
                    want.saturated !== m_data.saturated) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("mismatch at word %0d: expected %p, got %p",
                                 words_seen, want, m_data);
                end
            end
        end
    end

    // Receiver ready: random stalls, plus one long hold-off to fill the pipe.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (holdoff > 0) begin
            holdoff <= holdoff - 1;
            m_ready <= 1'b0;
        end else if (!holdoff_done && words_sent > 300) begin
            holdoff_done <= 1'b1;
            holdoff <= 150;
            m_ready <= 1'b0;
        end else if (recv_idle > 0) begin
            recv_idle <= recv_idle - 1;
            m_ready <= 1'b0;
        end else if (!calm_phase && $urandom_range(0, 9) == 0) begin
            recv_idle <= $urandom_range(0, 11);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("simulation failed");
            $finish;
        end
    end

endmodule
